@@ hdl/hsov_pkg.sv @@
package hsov_pkg;

  localparam int unsigned KEY_UPPER_W = 16;
  localparam int unsigned KEY_LOWER_W = 64;
  localparam int unsigned STEP_W      = 12;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CODE_W      = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 12'd30;
  localparam logic [7:0]        IPAD_BYTE  = 8'h36;
  localparam logic [7:0]        OPAD_BYTE  = 8'h5c;
  localparam logic [30:0]       MODULUS    = 31'd1000000;
  // floor(2^50 / 1000000), quotient estimate is low by at most one
  localparam logic [30:0]       RECIP      = 31'd1125899906;
  localparam int unsigned       RECIP_SH   = 50;
  localparam logic [159:0]      H_INIT     =
    160'h67452301_efcdab89_98badcfe_10325476_c3d2e1f0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_UPPER = 2'd0,
    CFG_KEY_LOWER = 2'd1,
    CFG_TIME_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] moving_value;
    logic [CODE_W-1:0]  candidate_code;
  } in_req_t;

  typedef struct packed {
    logic              match;
    logic [CODE_W-1:0] computed_code;
  } result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] factor;
    logic [CODE_W-1:0]  candidate;
  } job_t;

  typedef enum logic {
    FR_IDLE,
    FR_DIV
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROUND,
    BK_ADD,
    BK_TRUNC,
    BK_MOD,
    BK_OUT
  } bk_state_e;

endpackage

@@ hdl/hsov_fifo.sv @@
module hsov_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/hsov_front.sv @@
module hsov_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  hsov_pkg::in_req_t                    in_req_i,
  output logic                                 full_o,
  input  logic [hsov_pkg::STEP_W-1:0]          time_step_i,
  output logic                                 job_push_o,
  output hsov_pkg::job_t                       job_o,
  input  logic                                 job_full_i
);

  hsov_pkg::fr_state_e state_q, state_d;

  logic [hsov_pkg::VALUE_W-1:0] dq_q, dq_d, dq_n;
  logic [hsov_pkg::STEP_W-1:0]  rem_q, rem_d, rem_n, divisor;
  logic [hsov_pkg::STEP_W:0]    rem_sh;
  logic [5:0]                   cnt_q, cnt_d;
  logic [hsov_pkg::CODE_W-1:0]  cand_q, cand_d;
  logic                         hold_v_q, hold_v_d, ge, accept, drain, div_last;
  hsov_pkg::job_t               hold_q, hold_d;

  // zero step behaves as one
  assign divisor  = (time_step_i == '0) ? hsov_pkg::STEP_W'(1) : time_step_i;
  assign drain    = hold_v_q && !job_full_i;
  assign full_o   = (state_q == hsov_pkg::FR_DIV) || (hold_v_q && job_full_i);
  assign accept   = push_i && !full_o;
  assign div_last = (cnt_q == 6'd63);

  assign job_push_o = hold_v_q;
  assign job_o      = hold_q;

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q, dq_q[hsov_pkg::VALUE_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor});
  assign rem_n  = ge ? hsov_pkg::STEP_W'(rem_sh - {1'b0, divisor})
                     : rem_sh[hsov_pkg::STEP_W-1:0];
  assign dq_n   = {dq_q[hsov_pkg::VALUE_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsov_pkg::FR_IDLE: begin
        if (accept && in_req_i.req_type) begin
          state_d = hsov_pkg::FR_DIV;
        end
      end
      hsov_pkg::FR_DIV: begin
        if (div_last) begin
          state_d = hsov_pkg::FR_IDLE;
        end
      end
      default: state_d = hsov_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    dq_d     = dq_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    cand_d   = cand_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q && !drain;
    unique case (state_q)
      hsov_pkg::FR_IDLE: begin
        if (accept) begin
          if (in_req_i.req_type) begin
            dq_d   = in_req_i.moving_value;
            rem_d  = '0;
            cnt_d  = '0;
            cand_d = in_req_i.candidate_code;
          end else begin
            hold_v_d         = 1'b1;
            hold_d.factor    = in_req_i.moving_value;
            hold_d.candidate = in_req_i.candidate_code;
          end
        end
      end
      hsov_pkg::FR_DIV: begin
        dq_d  = dq_n;
        rem_d = rem_n;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          hold_v_d         = 1'b1;
          hold_d.factor    = dq_n;
          hold_d.candidate = cand_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hsov_pkg::FR_IDLE;
      hold_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    cand_q <= cand_d;
    hold_q <= hold_d;
  end

endmodule

@@ hdl/hsov_back.sv @@
module hsov_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 job_empty_i,
  input  hsov_pkg::job_t                       job_i,
  output logic                                 job_pop_o,
  input  logic [hsov_pkg::KEY_UPPER_W-1:0]     key_upper_i,
  input  logic [hsov_pkg::KEY_LOWER_W-1:0]     key_lower_i,
  input  logic                                 res_full_i,
  output logic                                 res_push_o,
  output hsov_pkg::result_t                    res_o
);

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // message block for each of the four compressions
  function automatic logic [511:0] build_block(
    input logic [1:0]   blk,
    input logic [15:0]  ku,
    input logic [63:0]  kl,
    input logic [63:0]  factor,
    input logic [159:0] dig
  );
    logic [511:0] key_blk;
    logic [7:0]   pad;
    key_blk = {ku, kl, 432'h0};
    pad     = blk[1] ? hsov_pkg::OPAD_BYTE : hsov_pkg::IPAD_BYTE;
    unique case (blk)
      2'd0, 2'd2: build_block = key_blk ^ {64{pad}};
      2'd1:       build_block = {factor, 32'h8000_0000, 384'h0, 32'h0000_0240};
      default:    build_block = {dig, 32'h8000_0000, 288'h0, 32'h0000_02a0};
    endcase
  endfunction

  hsov_pkg::bk_state_e state_q, state_d;

  logic [31:0]                 w_q [16];
  logic [31:0]                 w_d [16];
  logic [31:0]                 a_q, b_q, c_q, d_q, e_q;
  logic [31:0]                 a_d, b_d, c_d, d_d, e_d;
  logic [159:0]                h_q, h_d, dig_q, dig_d, h_sum;
  logic [6:0]                  rnd_q, rnd_d;
  logic [1:0]                  blk_q, blk_d;
  logic [1:0]                  k_q, k_d;
  logic [30:0]                 v_q, v_d, qd;
  logic [11:0]                 q_q, q_d;
  logic [61:0]                 prod;
  logic [hsov_pkg::VALUE_W-1:0] fac_q, fac_d;
  logic [hsov_pkg::CODE_W-1:0] cand_q, cand_d;
  logic [31:0]                 f, kc, t, w_new, sel;
  logic [511:0]                blk_bits;
  logic [1:0]                  blk_sel;
  logic [63:0]                 fac_sel;
  logic [3:0]                  ofs;

  assign h_sum = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
                  h_q[63:32] + d_q, h_q[31:0] + e_q};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f  = (b_q & c_q) | (~b_q & d_q);
      kc = 32'h5a827999;
    end else if (rnd_q < 7'd40) begin
      f  = b_q ^ c_q ^ d_q;
      kc = 32'h6ed9eba1;
    end else if (rnd_q < 7'd60) begin
      f  = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      kc = 32'h8f1bbcdc;
    end else begin
      f  = b_q ^ c_q ^ d_q;
      kc = 32'hca62c1d6;
    end
  end

  assign t     = rotl(a_q, 5) + f + e_q + kc + w_q[0];
  assign w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

  // next block to load: the first one from idle, the following one from add
  assign blk_sel  = (state_q == hsov_pkg::BK_IDLE) ? 2'd0 : blk_q + 2'd1;
  assign fac_sel  = (state_q == hsov_pkg::BK_IDLE) ? job_i.factor : fac_q;
  assign blk_bits = build_block(blk_sel, key_upper_i, key_lower_i, fac_sel, dig_q);

  // dynamic truncation picks four bytes at the nibble offset
  assign ofs = h_q[3:0];
  assign sel = h_q[8'd159 - {1'b0, ofs, 3'b000} -: 32];

  // modulo by reciprocal: 31 by 31 bit product, then remainder and one fix-up
  assign prod = {31'd0, v_q} * {31'd0, hsov_pkg::RECIP};
  assign qd   = {19'd0, q_q} * hsov_pkg::MODULUS;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hsov_pkg::BK_IDLE:  if (!job_empty_i) state_d = hsov_pkg::BK_ROUND;
      hsov_pkg::BK_ROUND: if (rnd_q == 7'd79) state_d = hsov_pkg::BK_ADD;
      hsov_pkg::BK_ADD: begin
        state_d = (blk_q == 2'd3) ? hsov_pkg::BK_TRUNC : hsov_pkg::BK_ROUND;
      end
      hsov_pkg::BK_TRUNC: state_d = hsov_pkg::BK_MOD;
      hsov_pkg::BK_MOD:   if (k_q == 2'd0) state_d = hsov_pkg::BK_OUT;
      hsov_pkg::BK_OUT:   if (!res_full_i) state_d = hsov_pkg::BK_IDLE;
      default:            state_d = hsov_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    w_d    = w_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    d_d    = d_q;
    e_d    = e_q;
    h_d    = h_q;
    dig_d  = dig_q;
    rnd_d  = rnd_q;
    blk_d  = blk_q;
    k_d    = k_q;
    v_d    = v_q;
    q_d    = q_q;
    fac_d  = fac_q;
    cand_d = cand_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      hsov_pkg::BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          fac_d     = job_i.factor;
          cand_d    = job_i.candidate;
          blk_d     = 2'd0;
          rnd_d     = '0;
          h_d       = hsov_pkg::H_INIT;
          {a_d, b_d, c_d, d_d, e_d} = hsov_pkg::H_INIT;
          for (int i = 0; i < 16; i++) w_d[i] = blk_bits[511-32*i -: 32];
        end
      end
      hsov_pkg::BK_ROUND: begin
        a_d   = t;
        b_d   = a_q;
        c_d   = rotl(b_q, 30);
        d_d   = c_q;
        e_d   = d_q;
        rnd_d = rnd_q + 1'b1;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = w_new;
      end
      hsov_pkg::BK_ADD: begin
        rnd_d = '0;
        blk_d = blk_q + 2'd1;
        if (blk_q == 2'd1) begin
          // inner digest kept, outer hash restarts from the initial value
          dig_d = h_sum;
          h_d   = hsov_pkg::H_INIT;
          {a_d, b_d, c_d, d_d, e_d} = hsov_pkg::H_INIT;
        end else begin
          h_d = h_sum;
          {a_d, b_d, c_d, d_d, e_d} = h_sum;
        end
        for (int i = 0; i < 16; i++) w_d[i] = blk_bits[511-32*i -: 32];
      end
      hsov_pkg::BK_TRUNC: begin
        v_d = sel[30:0];
        k_d = 2'd2;
      end
      hsov_pkg::BK_MOD: begin
        unique case (k_q)
          2'd2:    q_d = prod[hsov_pkg::RECIP_SH +: 12];
          2'd1:    v_d = v_q - qd;
          2'd0:    if (v_q >= hsov_pkg::MODULUS) v_d = v_q - hsov_pkg::MODULUS;
          default: ;
        endcase
        k_d = k_q - 1'b1;
      end
      hsov_pkg::BK_OUT: begin
        res_push_o = !res_full_i;
      end
      default: ;
    endcase
  end

  assign res_o.computed_code = v_q[hsov_pkg::CODE_W-1:0];
  assign res_o.match         = (v_q[hsov_pkg::CODE_W-1:0] == cand_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsov_pkg::BK_IDLE;
      rnd_q   <= '0;
      blk_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      blk_q   <= blk_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    e_q    <= e_d;
    h_q    <= h_d;
    dig_q  <= dig_d;
    v_q    <= v_d;
    q_q    <= q_d;
    fac_q  <= fac_d;
    cand_q <= cand_d;
  end

endmodule

@@ hdl/hmac_sha1_otp_validator.sv @@
// six-digit hotp/totp checker over hmac-sha1 with an 80-bit key. a request
// carries the mode, the counter or time and the candidate code; each request
// gives exactly one result (match flag and computed code) in request order.
// the front stage takes a hotp request at once; for totp it divides the time
// by the step one quotient bit per cycle and takes no request meanwhile.
// the back stage runs four sha-1 compressions of 80 rounds on one shared
// round unit, then truncates and reduces modulo one million in three steps
// (reciprocal multiply, remainder, one correction). it takes a new job only
// once the last result is pushed, and the shared round unit sets the
// sustained rate. a short queue sits between front and back, another holds
// results, so requests keep being taken while a result waits to be popped.
// configuration writes must only happen while the block is idle.
module hmac_sha1_otp_validator #(
  parameter int unsigned QUEUE_DEPTH = hsov_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request side
  input  logic                                 push_i,
  input  hsov_pkg::in_req_t                    in_req_i,
  output logic                                 full_o,
  // result side
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output hsov_pkg::result_t                    res_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [hsov_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hsov_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic [hsov_pkg::KEY_UPPER_W-1:0] key_upper_q;
  logic [hsov_pkg::KEY_LOWER_W-1:0] key_lower_q;
  logic [hsov_pkg::STEP_W-1:0]      time_step_q;

  logic           job_push, job_full, job_pop, job_empty;
  hsov_pkg::job_t job_in, job_out;
  logic           res_push, res_full;
  hsov_pkg::result_t res_in;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
      time_step_q <= hsov_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hsov_pkg::CFG_KEY_UPPER: key_upper_q <= cfg_data_i[hsov_pkg::KEY_UPPER_W-1:0];
        hsov_pkg::CFG_KEY_LOWER: key_lower_q <= cfg_data_i[hsov_pkg::KEY_LOWER_W-1:0];
        hsov_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[hsov_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // front: takes requests, works out the moving factor
  hsov_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_req_i    (in_req_i),
    .full_o      (full_o),
    .time_step_i (time_step_q),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  // job queue between the two stages
  hsov_fifo #(
    .WIDTH ($bits(hsov_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // back: hmac, truncation, modulo and compare
  hsov_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .key_upper_i (key_upper_q),
    .key_lower_i (key_lower_q),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue
  hsov_fifo #(
    .WIDTH ($bits(hsov_pkg::result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule
